FILE: sv/i2crm_pkg.sv
// Shared types, codes and constants of the I2C register master.
package i2crm_pkg;

  localparam int unsigned WRITE_DEPTH = 16;
  localparam int unsigned WBUF_AW = (WRITE_DEPTH > 1) ? $clog2(WRITE_DEPTH) : 1;
  localparam int unsigned FILL_W = $clog2(WRITE_DEPTH + 1);

  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;

  // Register index, taken from paddr bit 2
  localparam logic REG_ACK_TIMEOUT = 1'b0;
  localparam logic REG_UNIT_TICKS = 1'b1;

  localparam logic [7:0] ACK_TIMEOUT_RST = 8'd5;
  localparam logic [10:0] UNIT_TICKS_RST = 11'd1;
  localparam logic [10:0] UNIT_TICKS_MAX = 11'd1024;

  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_ADDR_NACK = 2'd1;
  localparam logic [1:0] STATUS_DATA_NACK = 2'd2;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_LOAD  = 2'd1,
    MODE_WRITE = 2'd2,
    MODE_READ  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STG_ADDR_W = 2'd0,
    STG_REG    = 2'd1,
    STG_DATA   = 2'd2,
    STG_ADDR_R = 2'd3
  } stage_e;

  typedef enum logic [4:0] {
    PH_IDLE      = 5'd0,
    PH_ST1       = 5'd1,
    PH_ST2       = 5'd2,
    PH_ST3       = 5'd3,
    PH_TX_LOW    = 5'd4,
    PH_TX_DATA   = 5'd5,
    PH_TX_HIGH   = 5'd6,
    PH_TX_END    = 5'd7,
    PH_ACK_REL   = 5'd8,
    PH_ACK_POLL  = 5'd9,
    PH_NEXT      = 5'd10,
    PH_RX_HIGH   = 5'd11,
    PH_RX_SAMPLE = 5'd12,
    PH_AK1       = 5'd13,
    PH_AK2       = 5'd14,
    PH_RXB       = 5'd15,
    PH_NK1       = 5'd16,
    PH_NK2       = 5'd17,
    PH_SP0       = 5'd18,
    PH_SP1       = 5'd19,
    PH_SP2       = 5'd20,
    PH_SP3       = 5'd21,
    PH_FIN       = 5'd22
  } phase_e;

  typedef struct packed {
    logic [1:0] mode;
    logic [6:0] dev_addr;
    logic [7:0] reg_addr;
    logic [7:0] byte_count;
    logic [7:0] data_byte;
    logic       sda_in;
  } in_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
  } out_t;

  typedef struct packed {
    logic [7:0]  ack_timeout;
    logic [10:0] unit_ticks;
  } cfg_t;

endpackage

FILE: sv/i2crm_wbuf.sv
// Write data buffer: single-port write, one registered read port.
module i2crm_wbuf #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 8,
  parameter int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: sv/i2crm_regs.sv
// Configuration registers behind the APB-style port.
module i2crm_regs import i2crm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic [APB_AW-1:0] paddr_i,
  input  logic [APB_DW-1:0] pwdata_i,
  output logic [APB_DW-1:0] prdata_o,
  output cfg_t              cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic wr_en;

  assign wr_en = psel_i && penable_i && pwrite_i;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (paddr_i[2])
        REG_ACK_TIMEOUT: cfg_d.ack_timeout = pwdata_i[7:0];
        REG_UNIT_TICKS:  cfg_d.unit_ticks = pwdata_i[10:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ack_timeout <= ACK_TIMEOUT_RST;
      cfg_q.unit_ticks <= UNIT_TICKS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    unique case (paddr_i[2])
      REG_ACK_TIMEOUT: prdata_o = {{(APB_DW - 8){1'b0}}, cfg_q.ack_timeout};
      REG_UNIT_TICKS:  prdata_o = {{(APB_DW - 11){1'b0}}, cfg_q.unit_ticks};
      default:         prdata_o = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

FILE: sv/i2crm_engine.sv
// Bus sequencer: one step per item, write bytes fetched from the buffer memory.
module i2crm_engine import i2crm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic step_i,
  input  in_t  item_i,
  input  cfg_t cfg_i,
  output out_t res_o
);

  phase_e            phase_q, phase_d;
  stage_e            stage_q, stage_d;
  logic [3:0]        bit_q, bit_d;
  logic [10:0]       wait_q, wait_d;
  logic [7:0]        ackw_q, ackw_d;
  logic [7:0]        shift_q, shift_d;
  logic [7:0]        left_q, left_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [FILL_W-1:0] pos_q, pos_d;
  logic [6:0]        taddr_q, taddr_d;
  logic [7:0]        treg_q, treg_d;
  logic              rd_q, rd_d;
  logic              scl_q, scl_d;
  logic              sda_q, sda_d;
  logic [1:0]        status_q, status_d;

  logic              valid, done, wr_en;
  logic [7:0]        left_n;
  logic [10:0]       unit_eff, dly1, dly2;
  logic [11:0]       unit_x2;
  logic [7:0]        rd_data;
  mode_e             mode;

  assign mode = mode_e'(item_i.mode);

  // Clamp the unit to 1..1024 ticks; a wait of n units loads n*unit-1
  always_comb begin
    if (cfg_i.unit_ticks == 11'd0) begin
      unit_eff = 11'd1;
    end else if (cfg_i.unit_ticks > UNIT_TICKS_MAX) begin
      unit_eff = UNIT_TICKS_MAX;
    end else begin
      unit_eff = cfg_i.unit_ticks;
    end
  end

  assign unit_x2 = {unit_eff, 1'b0};
  assign dly1 = unit_eff - 11'd1;
  assign dly2 = 11'(unit_x2 - 12'd1);

  i2crm_wbuf #(
    .DEPTH(WRITE_DEPTH),
    .WIDTH(8)
  ) u_wbuf (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(fill_q[WBUF_AW-1:0]),
    .wr_data_i(item_i.data_byte),
    .rd_addr_i(pos_q[WBUF_AW-1:0]),
    .rd_data_o(rd_data)
  );

  always_comb begin
    phase_d  = phase_q;
    stage_d  = stage_q;
    bit_d    = bit_q;
    wait_d   = wait_q;
    ackw_d   = ackw_q;
    shift_d  = shift_q;
    left_d   = left_q;
    fill_d   = fill_q;
    pos_d    = pos_q;
    taddr_d  = taddr_q;
    treg_d   = treg_q;
    rd_d     = rd_q;
    scl_d    = scl_q;
    sda_d    = sda_q;
    status_d = status_q;
    valid    = 1'b0;
    done     = 1'b0;
    wr_en    = 1'b0;
    left_n   = left_q;

    if (step_i) begin
      if (phase_q == PH_IDLE) begin
        if (mode == MODE_LOAD) begin
          if (fill_q < FILL_W'(WRITE_DEPTH)) begin
            wr_en  = 1'b1;
            fill_d = fill_q + FILL_W'(1);
          end
        end else if (mode == MODE_WRITE || mode == MODE_READ) begin
          taddr_d = item_i.dev_addr;
          treg_d  = item_i.reg_addr;
          rd_d    = (mode == MODE_READ);
          left_d  = item_i.byte_count;
          if (mode == MODE_WRITE) begin
            // Send no more bytes than the buffer holds, then empty it
            if ({1'b0, item_i.byte_count} > 9'(fill_q)) begin
              left_d = 8'(fill_q);
            end
            fill_d = '0;
          end
          pos_d    = '0;
          stage_d  = STG_ADDR_W;
          status_d = STATUS_OK;
          sda_d    = 1'b1;
          wait_d   = dly2;
          phase_d  = PH_ST1;
        end
      end else if (mode == MODE_TICK) begin
        if (wait_q != 11'd0) begin
          wait_d = wait_q - 11'd1;
        end else begin
          unique case (phase_q)
            PH_ST1: begin
              scl_d = 1'b1; wait_d = dly1; phase_d = PH_ST2;
            end
            PH_ST2: begin
              sda_d = 1'b0; wait_d = dly1; phase_d = PH_ST3;
            end
            PH_ST3: begin
              scl_d   = 1'b0;
              wait_d  = dly1;
              shift_d = {taddr_q, stage_q == STG_ADDR_R};
              bit_d   = 4'd0;
              phase_d = PH_TX_LOW;
            end
            PH_TX_LOW: begin
              scl_d = 1'b0; wait_d = dly2; phase_d = PH_TX_DATA;
            end
            PH_TX_DATA: begin
              sda_d   = shift_q[7];
              shift_d = {shift_q[6:0], 1'b0};
              wait_d  = dly2;
              phase_d = PH_TX_HIGH;
            end
            PH_TX_HIGH: begin
              scl_d   = 1'b1;
              wait_d  = dly1;
              bit_d   = bit_q + 4'd1;
              phase_d = (bit_d >= 4'd8) ? PH_TX_END : PH_TX_LOW;
            end
            PH_TX_END: begin
              scl_d = 1'b0; wait_d = dly2; phase_d = PH_ACK_REL;
            end
            PH_ACK_REL: begin
              sda_d   = 1'b1;
              scl_d   = 1'b1;
              ackw_d  = cfg_i.ack_timeout;
              wait_d  = dly1;
              phase_d = PH_ACK_POLL;
            end
            PH_ACK_POLL: begin
              if (!item_i.sda_in) begin
                scl_d = 1'b0; wait_d = dly2; phase_d = PH_NEXT;
              end else if (ackw_q <= 8'd1) begin
                // No acknowledge in time: abort with stop
                status_d = (stage_q == STG_ADDR_W || stage_q == STG_ADDR_R) ?
                           STATUS_ADDR_NACK : STATUS_DATA_NACK;
                scl_d   = 1'b0;
                wait_d  = dly2;
                phase_d = PH_SP1;
              end else begin
                ackw_d = ackw_q - 8'd1;
                wait_d = dly1;
              end
            end
            PH_NEXT: begin
              if (stage_q == STG_ADDR_W) begin
                stage_d = STG_REG;
                shift_d = treg_q;
                bit_d   = 4'd0;
                scl_d   = 1'b0;
                wait_d  = dly2;
                phase_d = PH_TX_DATA;
              end else if (stage_q == STG_ADDR_R) begin
                if (left_q != 8'd0) begin
                  sda_d   = 1'b1;
                  scl_d   = 1'b0;
                  shift_d = 8'd0;
                  bit_d   = 4'd0;
                  wait_d  = dly2;
                  phase_d = PH_RX_HIGH;
                end else begin
                  sda_d = 1'b1; wait_d = dly1; phase_d = PH_NK1;
                end
              end else if (stage_q == STG_REG && rd_q) begin
                stage_d = STG_ADDR_R;
                sda_d   = 1'b1;
                wait_d  = dly2;
                phase_d = PH_ST1;
              end else if (left_q != 8'd0 && 9'(pos_q) < 9'(WRITE_DEPTH)) begin
                // Buffer word at pos_q was read on an earlier cycle
                shift_d = rd_data;
                pos_d   = pos_q + FILL_W'(1);
                left_d  = left_q - 8'd1;
                stage_d = STG_DATA;
                bit_d   = 4'd0;
                scl_d   = 1'b0;
                wait_d  = dly2;
                phase_d = PH_TX_DATA;
              end else begin
                scl_d = 1'b0; wait_d = dly2; phase_d = PH_SP1;
              end
            end
            PH_RX_HIGH: begin
              scl_d = 1'b1; wait_d = dly1; phase_d = PH_RX_SAMPLE;
            end
            PH_RX_SAMPLE: begin
              shift_d = {shift_q[6:0], item_i.sda_in};
              bit_d   = bit_q + 4'd1;
              if (bit_d < 4'd8) begin
                scl_d = 1'b0; wait_d = dly2; phase_d = PH_RX_HIGH;
              end else begin
                valid = 1'b1;
                if (left_q != 8'd0) begin
                  left_n = left_q - 8'd1;
                end
                left_d  = left_n;
                scl_d   = 1'b0;
                sda_d   = (left_n == 8'd0);
                wait_d  = dly1;
                phase_d = (left_n != 8'd0) ? PH_AK1 : PH_NK1;
              end
            end
            PH_AK1: begin
              scl_d = 1'b1; wait_d = dly1; phase_d = PH_AK2;
            end
            PH_AK2: begin
              scl_d = 1'b0; wait_d = dly1; phase_d = PH_RXB;
            end
            PH_RXB: begin
              sda_d   = 1'b1;
              scl_d   = 1'b0;
              shift_d = 8'd0;
              bit_d   = 4'd0;
              wait_d  = dly2;
              phase_d = PH_RX_HIGH;
            end
            PH_NK1: begin
              scl_d = 1'b1; wait_d = dly1; phase_d = PH_NK2;
            end
            PH_NK2: begin
              scl_d = 1'b0; wait_d = dly2; phase_d = PH_SP0;
            end
            PH_SP0: begin
              scl_d = 1'b0; wait_d = dly2; phase_d = PH_SP1;
            end
            PH_SP1: begin
              sda_d = 1'b0; wait_d = dly1; phase_d = PH_SP2;
            end
            PH_SP2: begin
              scl_d = 1'b1; wait_d = dly1; phase_d = PH_SP3;
            end
            PH_SP3: begin
              sda_d = 1'b1; wait_d = dly1; phase_d = PH_FIN;
            end
            PH_FIN: begin
              done    = 1'b1;
              rd_d    = 1'b0;
              phase_d = PH_IDLE;
            end
            default: phase_d = PH_IDLE;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      stage_q  <= STG_ADDR_W;
      bit_q    <= '0;
      wait_q   <= '0;
      ackw_q   <= '0;
      shift_q  <= '0;
      left_q   <= '0;
      fill_q   <= '0;
      pos_q    <= '0;
      taddr_q  <= '0;
      treg_q   <= '0;
      rd_q     <= 1'b0;
      scl_q    <= 1'b1;
      sda_q    <= 1'b1;
      status_q <= STATUS_OK;
    end else begin
      phase_q  <= phase_d;
      stage_q  <= stage_d;
      bit_q    <= bit_d;
      wait_q   <= wait_d;
      ackw_q   <= ackw_d;
      shift_q  <= shift_d;
      left_q   <= left_d;
      fill_q   <= fill_d;
      pos_q    <= pos_d;
      taddr_q  <= taddr_d;
      treg_q   <= treg_d;
      rd_q     <= rd_d;
      scl_q    <= scl_d;
      sda_q    <= sda_d;
      status_q <= status_d;
    end
  end

  always_comb begin
    res_o.scl_level  = scl_d;
    res_o.sda_level  = sda_d;
    res_o.read_byte  = valid ? shift_d : 8'd0;
    res_o.read_valid = valid;
    res_o.busy_res   = (phase_d != PH_IDLE);
    res_o.done_res   = done;
    res_o.status     = status_d;
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(WRITE_DEPTH))
    else $error("write buffer fill beyond depth");

  a_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && phase_q != PH_IDLE && mode == MODE_LOAD) |=> $stable(fill_q))
    else $error("load accepted while a transaction runs");

  a_scl_low_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_TX_DATA) |-> !scl_q)
    else $error("SDA may change only while SCL is held low");
`endif

endmodule

FILE: sv/i2c_register_master_core.sv
// I2C register master: item channel, result channel, config port and output buffering.
//
//   channel  dir  handshake                          payload
//   in       in   in_valid_i / in_ready_o            in_data_i  (in_t)
//   out      out  out_valid_o / out_ready_i          out_data_o (out_t)
//   cfg      in   psel, penable, pwrite, pready      paddr, pwdata, prdata
//
// One result per item; the sequencer takes one item per cycle unless input is held off.
// Bus delays are counted in tick items, not clock cycles; write bytes come from the
// buffer memory, read through a registered port ahead of use. Results sit in an output
// register with a skid stage; input is held off only while both are full. Reset is
// asynchronous, active low, and needs no clearing pass.
module i2c_register_master_core import i2crm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_t               in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_t              out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  cfg_t cfg;
  out_t res;
  out_t out_q, out_d, skid_q, skid_d;
  logic out_v_q, out_v_d, skid_v_q, skid_v_d;
  logic push, pop;

  i2crm_regs u_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel_i   (psel),
    .penable_i(penable),
    .pwrite_i (pwrite),
    .paddr_i  (paddr),
    .pwdata_i (pwdata),
    .prdata_o (prdata),
    .cfg_o    (cfg)
  );

  i2crm_engine u_engine (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(push),
    .item_i(in_data_i),
    .cfg_i (cfg),
    .res_o (res)
  );

  assign pready = 1'b1;
  assign in_ready_o = !skid_v_q;
  assign push = in_valid_i && in_ready_o;
  assign pop = out_v_q && out_ready_i;

  always_comb begin
    out_d    = out_q;
    out_v_d  = out_v_q;
    skid_d   = skid_q;
    skid_v_d = skid_v_q;
    if (push) begin
      if (!out_v_q || pop) begin
        out_d   = res;
        out_v_d = 1'b1;
      end else begin
        // Output still waiting: park the new result
        skid_d   = res;
        skid_v_d = 1'b1;
      end
    end else if (pop) begin
      if (skid_v_q) begin
        out_d    = skid_q;
        skid_v_d = 1'b0;
      end else begin
        out_v_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_v_q;
  assign out_data_o = out_q;

`ifndef SYNTHESIS
  a_skid_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid stage full while output register empty");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_q.done_res) |-> !out_q.busy_res)
    else $error("transaction reported done while still busy");

  a_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_q.read_valid) |-> (out_q.busy_res && !out_q.done_res))
    else $error("received byte outside a running transaction");
`endif

endmodule
